/* hw/rtl/mbp_pkg.sv */
package mbp_pkg;

    localparam int DEF_MAX_VERTICES = 256;
    localparam int DEF_MAX_MODES    = 64;
    localparam int READ_LIMIT       = 64;
    localparam int DATA_W           = 32;
    localparam int ACC_W            = 48;
    localparam int FRAC_W           = 16;
    localparam int LANES            = 3;
    localparam int IN_TDATA_W       = 160;
    localparam int OUT_TDATA_W      = 136;

    typedef enum logic [2:0] {
        OP_LOAD_BASIS = 3'd0,
        OP_LOAD_Q     = 3'd1,
        OP_PROJ_VERT  = 3'd2,
        OP_PROJ_DOF   = 3'd3,
        OP_READ       = 3'd4,
        OP_ASSEMBLE   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_ASM_OUT,
        ST_RD_REQ,
        ST_RD_LOAD
    } state_t;

    localparam logic KIND_REDUCED = 1'b0;
    localparam logic KIND_DISP    = 1'b1;

    localparam logic REG_VERTICES = 1'b0;
    localparam logic REG_MODES    = 1'b1;

    typedef struct packed {
        logic capture;
        logic gate;
        logic clear;
        logic update;
    } lane_ctrl_t;

endpackage

/* hw/rtl/mbp_ram.sv */
module mbp_ram
    import mbp_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = DEF_MAX_MODES
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/mbp_lane.sv */
module mbp_lane
    import mbp_pkg::*;
#(
    parameter int SUMW = ACC_W + 6
)
(
    input  logic                     clk,
    input  lane_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] basis,
    input  logic signed [DATA_W-1:0] operand,
    output logic signed [ACC_W-1:0]  term,
    output logic signed [SUMW-1:0]   sum
);

    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [2*DATA_W-1:0] prod_next;
    logic signed [SUMW-1:0]     sum_reg;
    logic signed [SUMW-1:0]     sum_next;

    always_comb
    begin
        prod_next = prod_reg;
        if (ctrl.capture)
        begin
            if (ctrl.gate)
            begin
                prod_next = basis * operand;
            end
            else
            begin
                prod_next = '0;
            end
        end
    end

    // floor to Q32.16; the product magnitude is at most 2^62
    assign term = prod_reg[FRAC_W +: ACC_W];

    always_comb
    begin
        sum_next = sum_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.update)
        begin
            sum_next = sum_reg + SUMW'(term);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    assign sum = sum_reg;

endmodule

/* hw/rtl/mbp_merge.sv */
module mbp_merge
    import mbp_pkg::*;
#(
    parameter int SUMW = ACC_W + 6
)
(
    input  logic signed [ACC_W-1:0]  term [LANES],
    input  logic signed [ACC_W-1:0]  base,
    input  logic signed [SUMW-1:0]   sum [LANES],
    input  logic signed [ACC_W-1:0]  rd_val,
    output logic signed [ACC_W-1:0]  acc_wdata,
    output logic signed [DATA_W-1:0] disp [LANES],
    output logic signed [DATA_W-1:0] coord
);

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    assign acc_wdata = term[0] + term[1] + term[2] + base;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (&sum[i][SUMW-1:DATA_W-1] || ~|sum[i][SUMW-1:DATA_W-1])
            begin
                disp[i] = sum[i][DATA_W-1:0];
            end
            else
            begin
                disp[i] = sum[i][SUMW-1] ? SAT_MIN : SAT_MAX;
            end
        end
    end

    always_comb
    begin
        if (&rd_val[ACC_W-1:DATA_W-1] || ~|rd_val[ACC_W-1:DATA_W-1])
        begin
            coord = rd_val[DATA_W-1:0];
        end
        else
        begin
            coord = rd_val[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

endmodule

/* hw/rtl/modal_basis_projector_unit.sv */
// Channel   Dir  Handshake                    Contents
// s_axis    in   s_axis_tvalid/s_axis_tready  op in tuser, operands in tdata
// m_axis    out  m_axis_tvalid/m_axis_tready  kind in tuser, results in tdata, tlast
// apb       in   psel/penable/pready          vertices_in_use @0x0, modes_in_use @0x4
//
// Loads write their RAM as they are accepted. Project and assemble issue one mode per
// cycle through the basis RAM read port of each of the three lanes, then drain
// (multiply, accumulate, pipeline empty), and assemble then loads the output register
// once it is free. Readout moves through a request state and a load state per result on
// the single accumulator read port. Accumulators reset through per-mode valid bits, no
// clearing pass. A stalled output holds its result; new requests are taken meanwhile.
module modal_basis_projector_unit
    import mbp_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_MODES    = DEF_MAX_MODES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // row, mode, value, vertex, vx, vy, vz, accumulate, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [2:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_mode, coordinate, ux, uy, uz, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // kind
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int MW   = $clog2(MAX_MODES);
    localparam int VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW   = MW + 1;
    localparam int SUMW = ACC_W + MW;
    localparam int DIV3_MUL = 683;
    localparam int DIV3_SH  = 11;

    // configuration
    logic [8:0] verts_cfg_reg;
    logic [6:0] modes_cfg_reg;
    logic [8:0] nv;
    logic [6:0] nm;
    logic [6:0] rd_n;
    logic       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verts_cfg_reg <= 9'd256;
            modes_cfg_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_VERTICES)
            begin
                verts_cfg_reg <= pwdata[8:0];
            end
            else
            begin
                modes_cfg_reg <= pwdata[6:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_MODES) ? 32'(modes_cfg_reg) : 32'(verts_cfg_reg);

    assign nv   = (32'(verts_cfg_reg) > MAX_VERTICES) ? 9'(MAX_VERTICES) : verts_cfg_reg;
    assign nm   = (32'(modes_cfg_reg) > MAX_MODES) ? 7'(MAX_MODES) : modes_cfg_reg;
    assign rd_n = (nm > 7'(READ_LIMIT)) ? 7'(READ_LIMIT) : nm;

    // input unpack
    op_t                       in_op;
    logic [9:0]                in_row;
    logic [5:0]                in_mode;
    logic signed [DATA_W-1:0]  in_value;
    logic [7:0]                in_vertex;
    logic signed [DATA_W-1:0]  in_force [LANES];
    logic                      in_add;
    logic                      in_acc;

    assign in_op       = op_t'(s_axis_tuser);
    assign in_row      = s_axis_tdata[9:0];
    assign in_mode     = s_axis_tdata[15:10];
    assign in_value    = s_axis_tdata[47:16];
    assign in_vertex   = s_axis_tdata[55:48];
    assign in_force[0] = s_axis_tdata[87:56];
    assign in_force[1] = s_axis_tdata[119:88];
    assign in_force[2] = s_axis_tdata[151:120];
    assign in_add      = s_axis_tdata[152];
    assign in_acc      = s_axis_tvalid && s_axis_tready;

    // row -> vertex, component
    logic [19:0] row_mul;
    logic [8:0]  row_q;
    logic [10:0] row_rem;
    logic [1:0]  row_c;
    logic        row_ok;
    logic        vert_ok;
    logic        mode_ok;

    assign row_mul = 20'(in_row) * 20'(DIV3_MUL);
    assign row_q   = row_mul[DIV3_SH +: 9];
    assign row_rem = 11'(in_row) - 11'(row_q) * 11'd3;
    assign row_c   = row_rem[1:0];
    assign row_ok  = 11'(in_row) < 11'(nv) * 11'd3;
    assign vert_ok = 9'(in_vertex) < nv;
    assign mode_ok = 32'(in_mode) < MAX_MODES;

    // state
    state_t               state_reg;
    state_t               state_next;
    op_t                  op_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    logic                 v1_reg;
    logic                 v2_reg;
    logic [MW-1:0]        mode_d1_reg;
    logic [MW-1:0]        mode_d2_reg;
    logic                 vbit_d1_reg;
    logic [MAX_MODES-1:0] acc_vld_reg;
    logic                 add_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] force_reg [LANES];
    logic [1:0]           comp_reg;
    logic [VW-1:0]        bvert_reg;
    logic signed [ACC_W-1:0]  base_reg;

    logic issue;
    logic issue_last;
    logic rd_last;
    logic slot_free;
    logic load_asm;
    logic load_rd;
    logic is_proj;
    logic acc_sel_vld;
    logic out_valid_reg;

    assign issue_last = (9'(cnt_reg) + 9'd1) == 9'(nm);
    assign rd_last    = (9'(cnt_reg) + 9'd1) == 9'(rd_n);
    assign slot_free  = !out_valid_reg || m_axis_tready;
    assign is_proj    = (op_reg == OP_PROJ_VERT) || (op_reg == OP_PROJ_DOF);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_op)
                        OP_PROJ_VERT:
                        begin
                            if (vert_ok && nm != 7'd0)
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        OP_PROJ_DOF:
                        begin
                            if (row_ok && nm != 7'd0)
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        OP_READ:
                        begin
                            if (nm != 7'd0)
                            begin
                                state_next = ST_RD_REQ;
                            end
                        end
                        OP_ASSEMBLE:
                        begin
                            if (vert_ok)
                            begin
                                state_next = (nm != 7'd0) ? ST_RUN : ST_DRAIN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = (op_reg == OP_ASSEMBLE) ? ST_ASM_OUT : ST_IDLE;
                end
            end
            ST_ASM_OUT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_REQ:
            begin
                state_next = ST_RD_LOAD;
            end
            ST_RD_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = rd_last ? ST_IDLE : ST_RD_REQ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        load_asm      = 1'b0;
        load_rd       = 1'b0;
        cnt_next      = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cnt_next      = '0;
            end
            ST_RUN:
            begin
                issue    = 1'b1;
                cnt_next = cnt_reg + CW'(1);
            end
            ST_ASM_OUT:
            begin
                load_asm = slot_free;
            end
            ST_RD_LOAD:
            begin
                load_rd = slot_free;
                if (slot_free)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_LOAD_BASIS;
            cnt_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            acc_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (in_acc)
            begin
                op_reg <= in_op;
            end
            if (v2_reg && is_proj)
            begin
                acc_vld_reg[mode_d2_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            add_reg   <= in_add;
            value_reg <= in_value;
            comp_reg  <= row_c;
            bvert_reg <= (in_op == OP_PROJ_DOF) ? VW'(row_q) : VW'(in_vertex);
            for (int i = 0; i < LANES; i++)
            begin
                force_reg[i] <= in_force[i];
            end
        end
        mode_d1_reg <= cnt_reg[MW-1:0];
        vbit_d1_reg <= acc_vld_reg[cnt_reg[MW-1:0]];
        mode_d2_reg <= mode_d1_reg;
    end

    // memories
    logic signed [DATA_W-1:0] basis_rd [LANES];
    logic signed [DATA_W-1:0] q_rd;
    logic signed [ACC_W-1:0]  acc_rd;
    logic signed [ACC_W-1:0]  acc_wdata;
    logic signed [ACC_W-1:0]  term [LANES];
    logic signed [SUMW-1:0]   sum [LANES];
    logic signed [DATA_W-1:0] disp [LANES];
    logic signed [DATA_W-1:0] coord;
    logic signed [ACC_W-1:0]  rd_val;

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            base_reg <= (add_reg && vbit_d1_reg) ? acc_rd : '0;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic                     b_we;
        logic signed [DATA_W-1:0] operand;
        lane_ctrl_t               ctrl;

        assign b_we = in_acc && (in_op == OP_LOAD_BASIS) && row_ok && mode_ok
                      && (row_c == 2'(g));

        mbp_ram #(
            .WIDTH (DATA_W),
            .DEPTH (2**(VW+MW))
        ) u_basis (
            .clk   (clk),
            .we    (b_we),
            .waddr ({VW'(row_q), MW'(in_mode)}),
            .wdata (in_value),
            .raddr ({bvert_reg, cnt_reg[MW-1:0]}),
            .rdata (basis_rd[g])
        );

        always_comb
        begin
            case (op_reg)
                OP_PROJ_VERT: operand = force_reg[g];
                OP_PROJ_DOF:  operand = value_reg;
                default:      operand = q_rd;
            endcase
        end

        assign ctrl.capture = v1_reg;
        assign ctrl.gate    = (op_reg != OP_PROJ_DOF) || (comp_reg == 2'(g));
        assign ctrl.clear   = in_acc && (in_op == OP_ASSEMBLE);
        assign ctrl.update  = v2_reg && (op_reg == OP_ASSEMBLE);

        mbp_lane #(
            .SUMW (SUMW)
        ) u_lane (
            .clk     (clk),
            .ctrl    (ctrl),
            .basis   (basis_rd[g]),
            .operand (operand),
            .term    (term[g]),
            .sum     (sum[g])
        );
    end

    mbp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2**MW)
    ) u_q (
        .clk   (clk),
        .we    (in_acc && (in_op == OP_LOAD_Q) && mode_ok),
        .waddr (MW'(in_mode)),
        .wdata (in_value),
        .raddr (cnt_reg[MW-1:0]),
        .rdata (q_rd)
    );

    mbp_ram #(
        .WIDTH (ACC_W),
        .DEPTH (2**MW)
    ) u_acc (
        .clk   (clk),
        .we    (v2_reg && is_proj),
        .waddr (mode_d2_reg),
        .wdata (acc_wdata),
        .raddr (cnt_reg[MW-1:0]),
        .rdata (acc_rd)
    );

    assign acc_sel_vld = acc_vld_reg[cnt_reg[MW-1:0]];
    assign rd_val      = acc_sel_vld ? acc_rd : '0;

    mbp_merge #(
        .SUMW (SUMW)
    ) u_merge (
        .term      (term),
        .base      (base_reg),
        .sum       (sum),
        .rd_val    (rd_val),
        .acc_wdata (acc_wdata),
        .disp      (disp),
        .coord     (coord)
    );

    // output register
    logic                     kind_reg;
    logic [5:0]               omode_reg;
    logic signed [DATA_W-1:0] coord_reg;
    logic signed [DATA_W-1:0] disp_reg [LANES];
    logic                     last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= load_asm || load_rd || (out_valid_reg && !m_axis_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_asm)
        begin
            kind_reg  <= KIND_DISP;
            omode_reg <= '0;
            coord_reg <= '0;
            last_reg  <= 1'b1;
            for (int i = 0; i < LANES; i++)
            begin
                disp_reg[i] <= disp[i];
            end
        end
        else if (load_rd)
        begin
            kind_reg  <= KIND_REDUCED;
            omode_reg <= 6'(cnt_reg);
            coord_reg <= coord;
            last_reg  <= rd_last;
            for (int i = 0; i < LANES; i++)
            begin
                disp_reg[i] <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {2'b00, disp_reg[2], disp_reg[1], disp_reg[0], coord_reg, omode_reg};

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load_asm || load_rd) |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten while a result waits");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (9'(cnt_reg) < 9'(nm)))
        else $error("mode counter ran past the active mode count");

    a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || v2_reg) |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("lane pipeline active outside project or assemble");

    a_acc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_LOAD) |-> $past(state_reg) == ST_RD_REQ
                                   || $past(state_reg) == ST_RD_LOAD)
        else $error("readout data taken without a read cycle");

endmodule
